// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the array block; the request sequencer (iaid_ctrl) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while the active-low reset is asserted.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_SYNC(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/iaid_pkg.sv =====
// Types and constants shared by the indexed array blocks.
`timescale 1ns / 1ps
`default_nettype none

package iaid_pkg;

    localparam int unsigned DEPTH_DEF   = 256;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                     kind;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  word;
    } t_req;

    // status sits in the low bits
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/iaid_ram.sv =====
// Word store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module iaid_ram #(
    parameter int unsigned DEPTH = iaid_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [iaid_pkg::WORD_W-1:0]   i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [iaid_pkg::WORD_W-1:0]   o_rdata
);
    import iaid_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/iaid_ctrl.sv =====
// Request sequencer: decodes a request and walks the store to shift or search.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module iaid_ctrl #(
    parameter int unsigned DEPTH = iaid_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iaid_pkg::t_req                i_req,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    output iaid_pkg::t_result                  o_res,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic                               o_mem_we,
    output logic      [AW-1:0]                 o_mem_waddr,
    output logic      [iaid_pkg::WORD_W-1:0]   o_mem_wdata,
    output logic                               o_mem_re,
    output logic      [AW-1:0]                 o_mem_raddr,
    input  wire logic [iaid_pkg::WORD_W-1:0]   i_mem_rdata
);
    import iaid_pkg::*;

    localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_REPLY
    } t_state;

    t_state            r_state,   n_state;
    logic [CW-1:0]     r_used,    n_used;
    logic              r_rd_vld,  n_rd_vld;
    t_kind             r_op,      n_op;
    logic [AW-1:0]     r_pos,     n_pos;
    logic [AW-1:0]     r_ptr,     n_ptr;
    logic [AW-1:0]     r_end,     n_end;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [WORD_W-1:0] r_word,    n_word;
    logic              r_found,   n_found;
    t_status           r_status,  n_status;

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     used_x;
    logic [CW-1:0]     used_m1;
    logic              full;

    assign pos_x   = XW'(i_req.position);
    assign used_x  = XW'(r_used);
    assign used_m1 = r_used - CW'(1);
    assign full    = (r_used == CW'(DEPTH));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_op        = r_op;
        n_pos       = r_pos;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_word      = r_word;
        n_found     = r_found;
        n_status    = r_status;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_ptr;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr;

        // write back or compare the word read in the previous cycle
        if (r_rd_vld) begin
            case (r_op)
                KIND_INSERT: begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_rd_addr + AW'(1);
                end
                KIND_DELETE: begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_rd_addr - AW'(1);
                end
                KIND_QUERY: begin
                    if (i_mem_rdata == r_word) begin
                        n_found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.kind;
                    n_word   = i_req.word;
                    n_found  = 1'b0;
                    n_status = ST_DONE;
                    n_state  = S_REPLY;
                    unique case (i_req.kind)
                        KIND_INSERT: begin
                            n_pos = pos_x[AW-1:0];
                            n_end = pos_x[AW-1:0];
                            n_ptr = used_m1[AW-1:0];
                            if (pos_x > used_x) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_x == used_x) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_APPEND: begin
                            n_pos = r_used[AW-1:0];
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        KIND_DELETE: begin
                            n_ptr = pos_x[AW-1:0] + AW'(1);
                            n_end = used_m1[AW-1:0];
                            if (pos_x >= used_x) begin
                                n_status = ST_RANGE;
                            end else if (pos_x + XW'(1) == used_x) begin
                                n_used = used_m1;
                            end else begin
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_QUERY: begin
                            n_ptr = '0;
                            n_end = used_m1[AW-1:0];
                            if (r_used != '0) begin
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_mem_re  = 1'b1;
                n_rd_vld  = 1'b1;
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end else if (r_op == KIND_INSERT) begin
                    n_ptr = r_ptr - AW'(1);
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_DRAIN: begin
                if (r_op == KIND_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    if (r_op == KIND_DELETE) begin
                        n_used = used_m1;
                    end
                    n_state = S_REPLY;
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos;
                o_mem_wdata = r_word;
                n_used      = r_used + CW'(1);
                n_state     = S_REPLY;
            end
            S_REPLY: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_rd_vld <= n_rd_vld;
        end
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_ptr     <= n_ptr;
        r_end     <= n_end;
        r_rd_addr <= n_rd_addr;
        r_word    <= n_word;
        r_found   <= n_found;
        r_status  <= n_status;
    end

    logic [XW-1:0] count_x;
    assign count_x = XW'(r_used);

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_REPLY);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.count  = count_x[COUNT_W-1:0];

    `ASSERT_SYNC(a_used_bound, i_clk, i_rst_n, r_used <= CW'(DEPTH))
    `ASSERT_SYNC(a_put_port_free, i_clk, i_rst_n, (r_state == S_PUT) |-> !r_rd_vld)
    `ASSERT_SYNC(a_used_steady, i_clk, i_rst_n,
        (r_state == S_SHIFT || r_state == S_REPLY) |=> (r_used == $past(r_used)))
    `ASSERT_SYNC(a_reply_drained, i_clk, i_rst_n, (r_state == S_REPLY) |-> !r_rd_vld)

endmodule

`default_nettype wire

// ===== rtl/core/indexed_array_insert_delete.sv =====
// Throughput: one request at a time; shifts and searches move one stored word per cycle
// through the store's single write and single read port.
// The result register lets the next request start while a result waits on the master side.
// Reset (synchronous, active low) empties the array and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_insert_delete #(
    parameter int unsigned DEPTH = iaid_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // position[8:0], word[40:9], zero pad
    input  wire logic [iaid_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  wire logic [iaid_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // status[1:0], found[2], count[11:3], zero pad
    output logic      [iaid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import iaid_pkg::*;

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned OUT_P = OUT_TDATA_W - $bits(t_result);

    t_req              req;
    t_result           res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              r_out_valid;
    t_result           r_out_res;

    assign req.kind     = t_kind'(s_axis_tuser[KIND_W-1:0]);
    assign req.position = s_axis_tdata[POS_W-1:0];
    assign req.word     = s_axis_tdata[POS_W+WORD_W-1:POS_W];

    iaid_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    iaid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // load a new result when the register is empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_P{1'b0}}, r_out_res};

endmodule

`default_nettype wire

// ===== tb/indexed_array_insert_delete_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the indexed array block: directed and random requests, scoreboard.
module indexed_array_insert_delete_tb;
    import iaid_pkg::*;

    localparam int unsigned DEPTH       = DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned HOLD_AT_REQ = 40;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned TAIL_WAIT   = DEPTH + 16;

    typedef struct {
        t_kind                    kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word;
        bit                       wait_empty;  // hold back until every result is in
        bit                       calm;        // no idling while this one is offered
    } t_stim;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // position[8:0], word[40:9], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // kind[1:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status[1:0], found[2], count[11:3], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // array predictor state
    logic signed [WORD_W-1:0] array_words[DEPTH];
    int unsigned              array_used = 0;

    t_stim       pending_reqs[$];
    t_result     expected_results[$];
    t_stim       in_flight;
    bit          calm_now       = 1'b0;
    int unsigned long_hold_left = 0;
    bit          hold_done      = 1'b0;

    int unsigned cycle_cnt    = 0;
    int unsigned reqs_sent    = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned kind_cnt[4]  = '{default: 0};
    int unsigned range_cnt    = 0;
    int unsigned full_cnt     = 0;
    int unsigned hit_cnt      = 0;
    int unsigned peak_used    = 0;

    // generator side
    int unsigned              gen_used = 0;
    bit                       gen_calm = 1'b0;
    bit                       gen_wait = 1'b0;
    logic signed [WORD_W-1:0] word_pool[8];

    indexed_array_insert_delete #(.DEPTH(DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result apply_request(t_kind kind, logic [POS_W-1:0] pos,
                                              logic signed [WORD_W-1:0] word);
        t_result res;
        res.status = ST_DONE;
        res.found  = 1'b0;
        case (kind)
            KIND_INSERT: begin
                if (pos > array_used) begin
                    res.status = ST_RANGE;
                end else if (array_used >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = array_used; i > pos; i--) array_words[i] = array_words[i-1];
                    array_words[pos] = word;
                    array_used++;
                end
            end
            KIND_APPEND: begin
                if (array_used >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    array_words[array_used] = word;
                    array_used++;
                end
            end
            KIND_DELETE: begin
                if (pos >= array_used) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < array_used; i++) array_words[i] = array_words[i+1];
                    array_used--;
                end
            end
            default: begin
                for (int i = 0; i < array_used; i++)
                    if (array_words[i] == word) res.found = 1'b1;
            end
        endcase
        res.count = COUNT_W'(array_used);
        return res;
    endfunction

    task automatic add_req(t_kind kind, int unsigned pos, logic signed [WORD_W-1:0] word);
        t_stim s;
        s.kind       = kind;
        s.position   = POS_W'(pos);
        s.word       = word;
        s.wait_empty = gen_wait;
        s.calm       = gen_calm;
        gen_wait     = 1'b0;
        pending_reqs.push_back(s);
        // track the count only, to aim positions at the live range
        case (kind)
            KIND_INSERT: if (pos <= gen_used && gen_used < DEPTH) gen_used++;
            KIND_APPEND: if (gen_used < DEPTH) gen_used++;
            KIND_DELETE: if (pos < gen_used) gen_used--;
            default: ;
        endcase
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic add_random_req(int unsigned grow_pct);
        int unsigned roll;
        int unsigned pos;
        t_kind       kind;
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
            kind = ($urandom_range(0, 2) == 0) ? KIND_APPEND : KIND_INSERT;
        else if (roll < grow_pct + 15)
            kind = KIND_QUERY;
        else
            kind = KIND_DELETE;
        if ($urandom_range(0, 4) == 0)
            pos = $urandom_range(0, DEPTH);
        else if (kind == KIND_DELETE && gen_used > 0)
            pos = $urandom_range(0, gen_used - 1);
        else
            pos = $urandom_range(0, gen_used);
        add_req(kind, pos, pick_word());
    endtask

    // sender: offer queued requests, predict each accepted transaction
    always @(posedge i_clk) begin : drive_proc
        bit          loaded;
        int unsigned gap_left;
        t_result     res;
        if (!i_rst_n) begin
            gap_left = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            loaded = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                res = apply_request(in_flight.kind, in_flight.position, in_flight.word);
                expected_results.push_back(res);
                reqs_sent++;
                kind_cnt[in_flight.kind]++;
                if (res.status == ST_RANGE) range_cnt++;
                if (res.status == ST_FULL) full_cnt++;
                if (res.found) hit_cnt++;
                if (array_used > peak_used) peak_used = array_used;
                loaded = 1'b0;
                if (!in_flight.calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (!loaded) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].wait_empty || expected_results.size() == 0)) begin
                    in_flight = pending_reqs.pop_front();
                    s_axis_tdata <= IN_TDATA_W'({in_flight.word, in_flight.position});
                    s_axis_tuser <= in_flight.kind;
                    calm_now     <= in_flight.calm;
                    loaded = 1'b1;
                end
            end
            s_axis_tvalid <= loaded;
        end
    end

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    endtask

    // receiver: check each result transaction, stall at random
    always @(posedge i_clk) begin : sink_proc
        t_result     got;
        t_result     want;
        logic        ready_next;
        int unsigned stall_left;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("result %0d arrived with nothing expected, tdata %h",
                             results_seen, m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) report_mismatch("status", want.status, got.status);
                if (got.found != want.found) report_mismatch("found", want.found, got.found);
                if (got.count != want.count) report_mismatch("count", want.count, got.count);
            end
        end
        if (long_hold_left != 0) begin
            ready_next = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if (!calm_now && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_axis_tready <= ready_next;
    end

    // one long receiver hold-off so results back up and the input stalls
    always @(posedge i_clk) begin
        if (!hold_done && reqs_sent >= HOLD_AT_REQ) begin
            long_hold_left <= HOLD_CYCLES;
            hold_done      <= 1'b1;
        end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        word_pool[0] = 32'sh8000_0000;
        word_pool[1] = 32'sh7FFF_FFFF;
        word_pool[2] = '0;
        word_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) word_pool[i] = $urandom;

        // empty store, extremes, each end of the array
        add_req(KIND_QUERY,  0, '0);
        add_req(KIND_DELETE, 0, '0);
        add_req(KIND_INSERT, 1, 32'sh1234_5678);
        add_req(KIND_INSERT, 0, 32'sh8000_0000);
        add_req(KIND_APPEND, DEPTH, 32'sh7FFF_FFFF);
        add_req(KIND_INSERT, 2, -32'sd1);
        add_req(KIND_INSERT, 1, '0);
        add_req(KIND_INSERT, DEPTH, 32'sh5555_5555);
        add_req(KIND_QUERY,  3, 32'sh8000_0000);
        add_req(KIND_QUERY,  0, 32'sh7FFF_FFFF);
        add_req(KIND_QUERY,  0, 32'sh0000_3039);
        add_req(KIND_DELETE, 4, '0);
        add_req(KIND_DELETE, 3, '0);
        add_req(KIND_DELETE, 0, '0);
        add_req(KIND_QUERY,  0, 32'sh8000_0000);
        add_req(KIND_DELETE, DEPTH, '0);
        add_req(KIND_APPEND, 0, 32'sh5555_5555);
        add_req(KIND_INSERT, 0, 32'shAAAA_AAAA);
        add_req(KIND_QUERY,  0, 32'shAAAA_AAAA);
        add_req(KIND_QUERY,  0, -32'sd1);

        for (int n = 0; n < 100; n++) add_random_req(45);

        // pause the sender until the scoreboard drains, then fill the store
        gen_wait = 1'b1;
        while (gen_used < DEPTH) begin
            gen_calm = (gen_used < DEPTH / 2);
            if ($urandom_range(0, 99) < 85)
                add_req(KIND_APPEND, $urandom_range(0, DEPTH), pick_word());
            else
                add_req(KIND_INSERT, $urandom_range(0, gen_used), pick_word());
        end

        // full store: rejects, then past-end insert one below full
        gen_calm = 1'b0;
        add_req(KIND_INSERT, DEPTH, 32'sh0BAD_F00D);
        add_req(KIND_INSERT, 0, 32'sh0BAD_F00D);
        add_req(KIND_APPEND, 0, 32'sh0BAD_F00D);
        add_req(KIND_QUERY,  0, word_pool[$urandom_range(0, 7)]);
        add_req(KIND_QUERY,  0, 32'sh0BAD_F00D);
        add_req(KIND_DELETE, DEPTH, '0);
        add_req(KIND_DELETE, DEPTH - 1, '0);
        add_req(KIND_INSERT, DEPTH, 32'sh0BAD_F00D);
        add_req(KIND_INSERT, DEPTH - 1, 32'sh7FFF_FFFF);
        add_req(KIND_INSERT, $urandom_range(0, DEPTH), pick_word());
        add_req(KIND_DELETE, 0, '0);

        for (int n = 0; n < 40; n++) add_random_req(50);

        gen_calm = 1'b1;
        for (int n = 0; n < 30; n++) add_random_req(30);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("%0d requests: %0d insert, %0d append, %0d delete, %0d query; peak count %0d",
                 reqs_sent, kind_cnt[KIND_INSERT], kind_cnt[KIND_APPEND],
                 kind_cnt[KIND_DELETE], kind_cnt[KIND_QUERY], peak_used);
        $display("%0d out-of-range, %0d full rejects, %0d query hits, %0d results checked",
                 range_cnt, full_cnt, hit_cnt, results_seen);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
